[rtl/core/rle4_pkg.sv]
// Shared types and constants for the four-type run-length decoder.
package rle4_pkg;

    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 6;
    localparam int TOTAL_W = 16;

    // header layout
    localparam int                TYPE_SHIFT = 6;
    localparam logic [BYTE_W-1:0] COUNT_MASK = 8'h3F;

    // chunk types
    localparam logic [1:0] CT_FILL    = 2'd0;
    localparam logic [1:0] CT_REPEAT  = 2'd1;
    localparam logic [1:0] CT_PAIR    = 2'd2;
    localparam logic [1:0] CT_LITERAL = 2'd3;

    // one expansion job from front to back
    typedef struct packed {
        logic [BYTE_W-1:0] byte_a;
        logic [BYTE_W-1:0] byte_b;
        logic              pair;
        logic              last_on_end;
        logic [CNT_W-1:0]  cnt_m1;
    } rle4_cmd_t;

endpackage

[rtl/core/rle_four_type_decoder.sv]
// Four-type run-length decoder top level.
// Takes the compressed stream one byte per beat and expands it. A header byte
// carries the chunk type in bits 7..6 and count-1 in bits 5..0: fill (count
// copies of the fill_byte register), repeat (count copies of the next byte),
// pair (next two bytes, count times) and literal (next count bytes as is).
// The front end parses bytes into expansion jobs and takes one input beat per
// cycle while the job queue has room; non-fill header bytes and the first
// byte of a pair make no job. The back end turns each job into result beats,
// one per cycle while out_ready does not stall it; the input stalls only once
// the queue (QUEUE_DEPTH jobs) is full behind a long run.
// Each result carries one or two bytes, a chunk-last mark and the 16-bit
// wrapping total of decoded bytes. fill_byte is latched on a cfg handshake and
// used when a fill header is parsed; write it only while the decoder is idle.
// The stream never ends: the byte after each chunk is a header again.
module rle_four_type_decoder
    import rle4_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [BYTE_W-1:0]  in_byte,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [BYTE_W-1:0]  fill_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [BYTE_W-1:0]  byte_first,
    output logic [BYTE_W-1:0]  byte_second,
    output logic               pair_flag,
    output logic               chunk_last,
    output logic [TOTAL_W-1:0] bytes_total
);

    rle4_cmd_t push_cmd, pop_cmd;
    logic      push_valid, push_ready;
    logic      pop_valid, pop_ready;

    // parser
    rle4_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .fill_byte  (fill_byte),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // job queue decouples parsing from expansion
    rle4_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    // expander with registered output
    rle4_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_cmd     (pop_cmd),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .byte_first  (byte_first),
        .byte_second (byte_second),
        .pair_flag   (pair_flag),
        .chunk_last  (chunk_last),
        .bytes_total (bytes_total)
    );

endmodule

[rtl/core/rle4_front.sv]
// Front end: parses headers and payload bytes into expansion jobs.
module rle4_front
    import rle4_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [BYTE_W-1:0] fill_byte,
    output logic              push_valid,
    input  logic              push_ready,
    output rle4_cmd_t         push_cmd
);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_DATA   = 2'd1;
    localparam logic [1:0] PH_SECOND = 2'd2;

    logic [1:0]        phase_reg, phase_next;
    logic [1:0]        type_reg, type_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [BYTE_W-1:0] held_reg, held_next;
    logic [BYTE_W-1:0] fill_reg;

    logic [1:0]        hdr_type;
    logic [CNT_W-1:0]  hdr_cnt_m1;
    logic              accept;
    logic              need_push;

    assign hdr_type   = 2'(in_byte >> TYPE_SHIFT);
    assign hdr_cnt_m1 = CNT_W'(in_byte & COUNT_MASK);
    assign in_ready   = push_ready;
    assign accept     = in_valid && in_ready;
    assign push_valid = in_valid && in_ready && need_push;
    assign cfg_ready  = 1'b1;

    always_comb
    begin
        phase_next = phase_reg;
        type_next  = type_reg;
        rem_next   = rem_reg;
        held_next  = held_reg;
        need_push  = 1'b0;
        push_cmd   = '{byte_a: in_byte, byte_b: '0, pair: 1'b0,
                       last_on_end: 1'b1, cnt_m1: rem_reg};
        case (phase_reg)
            PH_DATA:
            begin
                case (type_reg)
                    CT_REPEAT:
                    begin
                        need_push  = 1'b1;
                        phase_next = PH_HEADER;
                    end
                    CT_PAIR:
                    begin
                        held_next  = in_byte;
                        phase_next = PH_SECOND;
                    end
                    default:
                    begin
                        // literal: one result per byte
                        need_push                = 1'b1;
                        push_cmd.cnt_m1          = '0;
                        push_cmd.last_on_end     = (rem_reg == '0);
                        rem_next                 = rem_reg - 1'b1;
                        if (rem_reg == '0)
                        begin
                            phase_next = PH_HEADER;
                        end
                    end
                endcase
            end
            PH_SECOND:
            begin
                need_push       = 1'b1;
                push_cmd.byte_a = held_reg;
                push_cmd.byte_b = in_byte;
                push_cmd.pair   = 1'b1;
                phase_next      = PH_HEADER;
            end
            default:
            begin
                // header; unused phase code falls here too
                type_next = hdr_type;
                rem_next  = hdr_cnt_m1;
                if (hdr_type == CT_FILL)
                begin
                    need_push       = 1'b1;
                    push_cmd.byte_a = fill_reg;
                    push_cmd.cnt_m1 = hdr_cnt_m1;
                    phase_next      = PH_HEADER;
                end
                else
                begin
                    phase_next = PH_DATA;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            type_reg  <= CT_FILL;
            rem_reg   <= '0;
            held_reg  <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                type_reg  <= type_next;
                rem_reg   <= rem_next;
                held_reg  <= held_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                fill_reg <= fill_byte;
            end
        end
    end

endmodule

[rtl/core/rle4_fifo.sv]
// Small job queue between the front and back ends.
module rle4_fifo
    import rle4_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    output logic      push_ready,
    input  rle4_cmd_t push_cmd,
    output logic      pop_valid,
    input  logic      pop_ready,
    output rle4_cmd_t pop_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    rle4_cmd_t       mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   cnt_reg;
    logic            do_push, do_pop;

    assign push_ready = (cnt_reg != FULL_CNT);
    assign pop_valid  = (cnt_reg != '0);
    assign pop_cmd    = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

[rtl/core/rle4_back.sv]
// Back end: expands jobs into result beats and keeps the running total.
module rle4_back
    import rle4_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  rle4_cmd_t          pop_cmd,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [BYTE_W-1:0]  byte_first,
    output logic [BYTE_W-1:0]  byte_second,
    output logic               pair_flag,
    output logic               chunk_last,
    output logic [TOTAL_W-1:0] bytes_total
);

    rle4_cmd_t          cur_reg;
    logic               busy_reg;
    logic               out_valid_reg;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [BYTE_W-1:0]  first_reg, second_reg;
    logic               pair_reg, last_reg;
    logic               advance, load, job_done;

    assign advance    = busy_reg && (!out_valid_reg || out_ready);
    assign job_done   = advance && (cur_reg.cnt_m1 == '0);
    assign pop_ready  = !busy_reg || job_done;
    assign load       = pop_valid && pop_ready;
    assign total_next = total_reg + (cur_reg.pair ? 16'd2 : 16'd1);

    assign out_valid   = out_valid_reg;
    assign byte_first  = first_reg;
    assign byte_second = second_reg;
    assign pair_flag   = pair_reg;
    assign chunk_last  = last_reg;
    assign bytes_total = total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
        end
        else
        begin
            if (load)
            begin
                busy_reg <= 1'b1;
            end
            else if (job_done)
            begin
                busy_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                total_reg     <= total_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_reg <= pop_cmd;
        end
        else if (advance)
        begin
            cur_reg.cnt_m1 <= cur_reg.cnt_m1 - 1'b1;
        end
        if (advance)
        begin
            first_reg  <= cur_reg.byte_a;
            second_reg <= cur_reg.pair ? cur_reg.byte_b : '0;
            pair_reg   <= cur_reg.pair;
            last_reg   <= job_done && cur_reg.last_on_end;
        end
    end

endmodule
